/* rtl/core/sgfa_pkg.sv */
// ----------------------------------------------------------------------------
// sgfa_pkg
// Shared types and constants of the softened gravity force accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgfa_pkg;

	localparam int unsigned POS_W    = 32;
	localparam int unsigned MASS_W   = 16;
	localparam int unsigned EPS_W    = 32;
	localparam int unsigned GRAV_W   = 16;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV      = 2'd1;

	localparam logic [EPS_W-1:0]  SOFTENING_RST = 32'd655360;
	localparam logic [GRAV_W-1:0] GRAV_RST      = 16'd6554;

	// last counter values of the shared sequential units
	localparam logic [5:0] SQRT_LAST = 6'd29;
	localparam logic [5:0] DIV_LAST  = 6'd48;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_SQE,
		OP_GM,
		OP_NUMX,
		OP_NUMY,
		OP_NUMY2,
		OP_NORM,
		OP_SQI,
		OP_SQRT,
		OP_PMUL,
		OP_SHIFT,
		OP_DIVI,
		OP_DIV,
		OP_ACC
	} op_t;

	typedef struct packed {
		logic norm_done;
		logic d_zero;
		logic last;
		logic out_blocked;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/softened_gravity_force_accumulator.sv */
// ----------------------------------------------------------------------------
// softened_gravity_force_accumulator
// 2-D softened gravity: accumulates dx*G*m/d2^1.5, dy*G*m/d2^1.5 per pair.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_stall   | target_x/y, source_x/y, source_mass,
//          |                       | first, last
//  out     | out_valid / out_stall | acc_x, acc_y, saturated
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// No new pair is taken until the last one is through (in_stall). 30 square
// root steps and 49 divider steps dominate, plus 1 to 18 steps of the range
// normalizer, which depend on the magnitude of the distance.
// Zero distance skips the root and divider. Reset clears the sums and flag
// and loads the default softening and constant. A stalled result word holds
// only a pair carrying last; other pairs finish underneath it.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_gravity_force_accumulator import sgfa_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [POS_W-1:0] target_x,
	input  wire logic signed [POS_W-1:0] target_y,
	input  wire logic signed [POS_W-1:0] source_x,
	input  wire logic signed [POS_W-1:0] source_y,
	input  wire logic [MASS_W-1:0]       source_mass,
	input  wire logic                    first,
	input  wire logic                    last,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [SUM_W-1:0]      acc_x,
	output logic signed [SUM_W-1:0]      acc_y,
	output logic                         saturated,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [EPS_W-1:0]        cfg_data
);

	op_t        op;
	dp_status_t status;

	sgfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	sgfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.target_x    (target_x),
		.target_y    (target_y),
		.source_x    (source_x),
		.source_y    (source_y),
		.source_mass (source_mass),
		.first       (first),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.acc_x       (acc_x),
		.acc_y       (acc_y),
		.saturated   (saturated)
	);

endmodule

`default_nettype wire

/* rtl/core/sgfa_ctrl.sv */
// ----------------------------------------------------------------------------
// sgfa_ctrl
// Sequencer: steps the shared multiplier, normalizer, square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sgfa_ctrl import sgfa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire dp_status_t status,
	output op_t             op
);

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQE, S_GM, S_NUMX, S_NUMY, S_NUMY2,
		S_NORM, S_SQI, S_SQRT, S_PMUL, S_SHIFT, S_DIVI, S_DIV, S_ACC
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		case (state_q)
			S_IDLE:  op = in_valid ? OP_LOAD : OP_NONE;
			S_SQX:   op = OP_SQX;
			S_SQY:   op = OP_SQY;
			S_SQE:   op = OP_SQE;
			S_GM:    op = OP_GM;
			S_NUMX:  op = OP_NUMX;
			S_NUMY:  op = OP_NUMY;
			S_NUMY2: op = OP_NUMY2;
			S_NORM:  op = OP_NORM;
			S_SQI:   op = OP_SQI;
			S_SQRT:  op = OP_SQRT;
			S_PMUL:  op = OP_PMUL;
			S_SHIFT: op = OP_SHIFT;
			S_DIVI:  op = OP_DIVI;
			S_DIV:   op = OP_DIV;
			S_ACC:   op = (status.last && status.out_blocked) ? OP_NONE : OP_ACC;
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_SQX;
				S_SQX:   state_q <= S_SQY;
				S_SQY:   state_q <= S_SQE;
				S_SQE:   state_q <= S_GM;
				S_GM:    state_q <= S_NUMX;
				S_NUMX:  state_q <= S_NUMY;
				S_NUMY:  state_q <= S_NUMY2;
				S_NUMY2: state_q <= S_NORM;
				S_NORM: begin
					// zero distance adds nothing: go straight to the sums
					if (status.d_zero)
						state_q <= S_ACC;
					else if (status.norm_done)
						state_q <= S_SQI;
				end
				S_SQI: begin
					state_q <= S_SQRT;
					cnt_q   <= SQRT_LAST;
				end
				S_SQRT: begin
					if (cnt_q == '0)
						state_q <= S_PMUL;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				S_PMUL:  state_q <= S_SHIFT;
				S_SHIFT: state_q <= S_DIVI;
				S_DIVI: begin
					state_q <= S_DIV;
					cnt_q   <= DIV_LAST;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_ACC;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				S_ACC: begin
					// hold a last pair while the previous result word still waits
					if (!(status.last && status.out_blocked))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_SQX))
		else $error("accepted word did not start the sequence");

	a_sqrt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> (cnt_q <= SQRT_LAST))
		else $error("square root counter out of range");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ($past(state_q) == S_DIVI || $past(state_q) == S_DIV))
		else $error("divider entered without setup");

endmodule

`default_nettype wire

/* rtl/core/sgfa_dp.sv */
// ----------------------------------------------------------------------------
// sgfa_dp
// Datapath: shared multiplier, range normalizer, bitwise square root,
// restoring dividers, saturating sums, config and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sgfa_dp import sgfa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire op_t                  op,
	output dp_status_t                status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [EPS_W-1:0]     cfg_data,
	input  wire logic signed [POS_W-1:0] target_x,
	input  wire logic signed [POS_W-1:0] target_y,
	input  wire logic signed [POS_W-1:0] source_x,
	input  wire logic signed [POS_W-1:0] source_y,
	input  wire logic [MASS_W-1:0]    source_mass,
	input  wire logic                 first,
	input  wire logic                 last,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [SUM_W-1:0]   acc_x,
	output logic signed [SUM_W-1:0]   acc_y,
	output logic                      saturated
);

	logic [EPS_W-1:0]  softening_q;
	logic [GRAV_W-1:0] grav_q;

	logic [31:0] adx_q, ady_q;
	logic        negx_q, negy_q;
	logic [15:0] mass_q;
	logic        first_q, last_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic [31:0] gm_q;
	logic [63:0] d_q;
	logic [63:0] numx_q, numy_q;
	logic [63:0] m_q;
	logic signed [5:0] e_q;

	logic [59:0] v_q;
	logic [60:0] res_q;
	logic [58:0] bit_q;
	logic [60:0] sq_t;

	logic [59:0]  p_q;
	logic [157:0] nxw_q, nyw_q;
	logic [6:0]   s_amt;
	logic [59:0]  rx_q, ry_q;
	logic [48:0]  lox_q, loy_q;
	logic [48:0]  qx_q, qy_q;
	logic         ovfx_q, ovfy_q;
	logic [60:0]  rx_t, ry_t;

	logic signed [SUM_W-1:0] accum_x_q, accum_y_q;
	logic                    ovf_seen_q;
	logic signed [SUM_W-1:0] base_x, base_y, sum_x, sum_y;
	logic                    base_ovf, clip_x, clip_y;
	logic [48:0]             mag_x, mag_y;

	logic signed [32:0] dx, dy;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] acc_x_q, acc_y_q;
	logic                    sat_q;

	assign cfg_ready = 1'b1;

	assign dx = $signed({source_x[31], source_x}) - $signed({target_x[31], target_x});
	assign dy = $signed({source_y[31], source_y}) - $signed({target_y[31], target_y});

	// shared multiplier operand select
	always_comb begin
		case (op)
			OP_SQX:  begin mul_a = adx_q;               mul_b = adx_q; end
			OP_SQY:  begin mul_a = ady_q;               mul_b = ady_q; end
			OP_SQE:  begin mul_a = softening_q;         mul_b = softening_q; end
			OP_GM:   begin mul_a = {16'd0, grav_q};     mul_b = {16'd0, mass_q}; end
			OP_NUMX: begin mul_a = adx_q;               mul_b = prod_q[31:0]; end
			OP_NUMY: begin mul_a = ady_q;               mul_b = gm_q; end
			OP_PMUL: begin mul_a = {2'd0, m_q[29:0]};   mul_b = {2'd0, res_q[29:0]}; end
			default: begin mul_a = '0;                  mul_b = '0; end
		endcase
	end

	assign s_amt = 7'(7'sd52 - 7'(3 * e_q));
	assign sq_t  = res_q + {2'd0, bit_q};
	assign rx_t  = {rx_q, lox_q[48]};
	assign ry_t  = {ry_q, loy_q[48]};

	// term magnitude, capped at one unit of bit 48
	always_comb begin
		if (d_q == '0)
			mag_x = '0;
		else if (ovfx_q || (qx_q[48] && qx_q[47:0] != '0))
			mag_x = {1'b1, 48'd0};
		else
			mag_x = qx_q;
		if (d_q == '0)
			mag_y = '0;
		else if (ovfy_q || (qy_q[48] && qy_q[47:0] != '0))
			mag_y = {1'b1, 48'd0};
		else
			mag_y = qy_q;
	end

	function automatic logic [48:0] sat_sum(input logic signed [SUM_W-1:0] acc,
	                                        input logic neg, input logic [48:0] mag);
		logic signed [49:0] t;
		logic [48:0]        r;
		t = neg ? ({{2{acc[47]}}, acc} - {1'b0, mag}) : ({{2{acc[47]}}, acc} + {1'b0, mag});
		if (!t[49] && t[48:47] != 2'b00)
			r = {1'b1, 1'b0, {47{1'b1}}};
		else if (t[49] && t[48:47] != 2'b11)
			r = {1'b1, 1'b1, 47'd0};
		else
			r = {1'b0, t[47:0]};
		return r;
	endfunction

	always_comb begin
		base_x   = first_q ? '0 : accum_x_q;
		base_y   = first_q ? '0 : accum_y_q;
		base_ovf = first_q ? 1'b0 : ovf_seen_q;
		{clip_x, sum_x} = sat_sum(base_x, negx_q, mag_x);
		{clip_y, sum_y} = sat_sum(base_y, negy_q, mag_y);
	end

	always_comb begin
		status.norm_done   = (m_q[63:30] == '0) && (m_q[29:28] != 2'b00);
		status.d_zero      = (d_q == '0);
		status.last        = last_q;
		status.out_blocked = out_valid_q && out_stall;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			softening_q <= SOFTENING_RST;
			grav_q      <= GRAV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SOFTENING: softening_q <= cfg_data;
				CFG_GRAV:      grav_q      <= cfg_data[GRAV_W-1:0];
				default:       ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a * mul_b);
		case (op)
			OP_LOAD: begin
				adx_q   <= dx[32] ? 32'(-dx) : dx[31:0];
				ady_q   <= dy[32] ? 32'(-dy) : dy[31:0];
				negx_q  <= dx[32];
				negy_q  <= dy[32];
				mass_q  <= source_mass;
				first_q <= first;
				last_q  <= last;
			end
			OP_SQY: d_q <= {2'd0, prod_q[63:2]};
			OP_SQE: d_q <= d_q + {2'd0, prod_q[63:2]};
			OP_GM:  d_q <= d_q + {2'd0, prod_q[63:2]};
			OP_NUMX: begin
				gm_q <= prod_q[31:0];
				m_q  <= d_q;
				e_q  <= '0;
			end
			OP_NUMY:  numx_q <= prod_q;
			OP_NUMY2: numy_q <= prod_q;
			OP_NORM: begin
				if (m_q[63:30] != '0) begin
					m_q <= m_q >> 2;
					e_q <= e_q + 6'sd1;
				end else if (m_q[63:28] == '0) begin
					m_q <= m_q << 2;
					e_q <= e_q - 6'sd1;
				end
			end
			OP_SQI: begin
				v_q   <= {m_q[29:0], 30'd0};
				res_q <= '0;
				bit_q <= {1'b1, 58'd0};
			end
			OP_SQRT: begin
				if ({1'b0, v_q} >= sq_t) begin
					v_q   <= 60'({1'b0, v_q} - sq_t);
					res_q <= (res_q >> 1) + {2'd0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_SHIFT: begin
				p_q   <= prod_q[59:0];
				nxw_q <= {94'd0, numx_q} << s_amt;
				nyw_q <= {94'd0, numy_q} << s_amt;
			end
			OP_DIVI: begin
				ovfx_q <= (nxw_q[157:109] != '0) || (nxw_q[108:49] >= p_q);
				ovfy_q <= (nyw_q[157:109] != '0) || (nyw_q[108:49] >= p_q);
				rx_q   <= nxw_q[108:49];
				ry_q   <= nyw_q[108:49];
				lox_q  <= nxw_q[48:0];
				loy_q  <= nyw_q[48:0];
				qx_q   <= '0;
				qy_q   <= '0;
			end
			OP_DIV: begin
				if (rx_t >= {1'b0, p_q}) begin
					rx_q <= 60'(rx_t - {1'b0, p_q});
					qx_q <= {qx_q[47:0], 1'b1};
				end else begin
					rx_q <= rx_t[59:0];
					qx_q <= {qx_q[47:0], 1'b0};
				end
				if (ry_t >= {1'b0, p_q}) begin
					ry_q <= 60'(ry_t - {1'b0, p_q});
					qy_q <= {qy_q[47:0], 1'b1};
				end else begin
					ry_q <= ry_t[59:0];
					qy_q <= {qy_q[47:0], 1'b0};
				end
				lox_q <= lox_q << 1;
				loy_q <= loy_q << 1;
			end
			default: ;
		endcase
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_x_q  <= '0;
			accum_y_q  <= '0;
			ovf_seen_q <= 1'b0;
		end else if (op == OP_ACC) begin
			accum_x_q  <= sum_x;
			accum_y_q  <= sum_y;
			ovf_seen_q <= base_ovf || clip_x || clip_y;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_ACC && last_q) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACC && last_q) begin
			acc_x_q <= sum_x;
			acc_y_q <= sum_y;
			sat_q   <= base_ovf || clip_x || clip_y;
		end
	end

	assign out_valid = out_valid_q;
	assign acc_x     = acc_x_q;
	assign acc_y     = acc_y_q;
	assign saturated = sat_q;

	a_out_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op == OP_ACC && last_q))
		else $error("result word raised without a last word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && op == OP_ACC) |-> !last_q)
		else $error("pending result word overwritten");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_ACC && (clip_x || clip_y)) |=> ovf_seen_q)
		else $error("clip not recorded");

endmodule

`default_nettype wire

/* bench/softened_gravity_force_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// softened_gravity_force_accumulator_tb
// Drives body pairs through the accumulator, predicts each emitted
// acceleration word in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_gravity_force_accumulator_tb;
	import sgfa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [SUM_W:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W:0] ACC_MIN = -49'sh0_8000_0000_0000;
	localparam logic [63:0] TERM_CAP = 64'd1 << 48;

	typedef struct packed {
		logic signed [SUM_W-1:0] ax;
		logic signed [SUM_W-1:0] ay;
		logic                    sat;
	} accel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [POS_W-1:0] target_x = '0, target_y = '0, source_x = '0, source_y = '0;
	logic [MASS_W-1:0] source_mass = '0;
	logic first = 1'b0, last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SUM_W-1:0] acc_x, acc_y;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [EPS_W-1:0] cfg_data = '0;

	// predictor state
	logic [EPS_W-1:0]        eps_q = SOFTENING_RST;
	logic [GRAV_W-1:0]       grav_q = GRAV_RST;
	logic signed [SUM_W-1:0] sum_x = '0, sum_y = '0;
	logic                    clipped = 1'b0;

	accel_t expected_accels[$];
	int errors = 0;
	int results_seen = 0;
	bit stall_enable = 1'b1;

	softened_gravity_force_accumulator u_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] pull_magnitude(input logic [63:0] num, input logic [63:0] d);
		logic [63:0] m, p, r, q, bt;
		int e, s, i;
		if (d == 0 || num == 0) return 0;
		m = d;
		e = 0;
		r = 0;
		q = 0;
		while (m >= (64'd1 << 30)) begin m >>= 2; e++; end
		while (m < (64'd1 << 28)) begin m <<= 2; e--; end
		p = m * int_sqrt(m << 30);
		s = 52 - 3 * e;
		for (i = 63 + s; i >= 0; i--) begin
			bt = (i >= s && (i - s) < 64) ? ((num >> (i - s)) & 64'd1) : 64'd0;
			r = (r << 1) | bt;
			q <<= 1;
			if (r >= p) begin
				r -= p;
				q |= 64'd1;
			end
			if (q > TERM_CAP) q = TERM_CAP;
		end
		return q;
	endfunction

	function automatic logic signed [SUM_W-1:0] add_clipped(input logic signed [SUM_W-1:0] acc,
			input logic neg, input logic [63:0] mag);
		logic signed [SUM_W+1:0] t;
		t = neg ? ($signed({{2{acc[SUM_W-1]}}, acc}) - $signed({1'b0, mag[SUM_W:0]}))
			: ($signed({{2{acc[SUM_W-1]}}, acc}) + $signed({1'b0, mag[SUM_W:0]}));
		if (t > ACC_MAX) begin clipped = 1'b1; return ACC_MAX[SUM_W-1:0]; end
		if (t < ACC_MIN) begin clipped = 1'b1; return ACC_MIN[SUM_W-1:0]; end
		return t[SUM_W-1:0];
	endfunction

	task automatic predict_pair(input logic signed [31:0] tx, ty, sx, sy,
			input logic [15:0] m, input logic f, l);
		logic signed [63:0] dx, dy;
		logic [63:0] adx, ady, d, gm;
		dx = 64'(sx) - 64'(tx);
		dy = 64'(sy) - 64'(ty);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		d = ((adx * adx) >> 2) + ((ady * ady) >> 2) + ((64'(eps_q) * 64'(eps_q)) >> 2);
		gm = 64'(grav_q) * 64'(m);
		if (f) begin
			sum_x = '0;
			sum_y = '0;
			clipped = 1'b0;
		end
		sum_x = add_clipped(sum_x, dx < 0, pull_magnitude(adx * gm, d));
		sum_y = add_clipped(sum_y, dy < 0, pull_magnitude(ady * gm, d));
		if (l) expected_accels.insert(expected_accels.size(), accel_t'{sum_x, sum_y, clipped});
	endtask

	task automatic send_pair(input logic signed [31:0] tx, ty, sx, sy,
			input logic [15:0] m, input logic f, l);
		int gap;
		gap = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		source_x <= sx;
		source_y <= sy;
		source_mass <= m;
		first <= f;
		last <= l;
		predict_pair(tx, ty, sx, sy, m, f, l);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EPS_W-1:0] val);
		in_valid <= 1'b0;
		// hold off until every expected result word is in, then let the last pair drain
		wait (expected_accels.size() == 0);
		repeat (130) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SOFTENING) eps_q = val;
		else if (idx == CFG_GRAV) grav_q = val[GRAV_W-1:0];
	endtask

	// result checker and receiver stalls
	initial begin
		int w;
		w = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				accel_t e;
				results_seen++;
				if (expected_accels.size() == 0) begin
					$display("%0t unexpected word: acc_x %0d acc_y %0d sat %0b",
						$time, acc_x, acc_y, saturated);
					errors++;
				end else begin
					e = expected_accels.pop_front();
					if (acc_x !== e.ax) begin
						$display("%0t acc_x expected %0d actual %0d", $time, e.ax, acc_x);
						errors++;
					end
					if (acc_y !== e.ay) begin
						$display("%0t acc_y expected %0d actual %0d", $time, e.ay, acc_y);
						errors++;
					end
					if (saturated !== e.sat) begin
						$display("%0t saturated expected %0b actual %0b", $time, e.sat, saturated);
						errors++;
					end
				end
				// draw the wait for the next word
				w = stall_enable ? $urandom_range(0, 18) : 0;
			end else if (out_valid && w > 0) begin
				w--;
			end
			out_stall <= (w > 0);
		end
	end

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			2: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
		endcase
	endfunction

	task automatic test_directed();
		send_pair(0, 0, 32'sh0001_0000, 0, 16'h0100, 1, 1);
		send_pair(0, 0, 0, 0, 16'hFFFF, 1, 1);                    // zero offset
		send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			16'hFFFF, 1, 1);
		send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			16'hFFFF, 1, 1);
		send_pair(0, 0, 32'sh0000_0001, 32'shFFFF_FFFF, 16'hFFFF, 1, 0);
		send_pair(0, 0, 32'sh0000_0100, 32'sh0000_0001, 16'h0001, 0, 0);
		send_pair(0, 0, 32'shFFFF_0000, 32'sh0002_0000, 16'h8000, 0, 1);
		send_pair(0, 0, 32'sh0000_0010, 0, 16'h0000, 0, 1);        // carry over
		write_reg(CFG_SOFTENING, 32'd0);
		send_pair(0, 0, 0, 0, 16'hFFFF, 1, 1);                    // d2 exactly zero
		send_pair(0, 0, 32'sh0000_0001, 0, 16'hFFFF, 1, 0);       // d2 rounds to zero
		send_pair(0, 0, 32'sh0000_0001, 32'shFFFF_FFFF, 16'hFFFF, 0, 1);
		send_pair(0, 0, 32'sh0000_0002, 0, 16'h0001, 0, 1);       // term clips, flag set
		send_pair(0, 0, 32'sh0000_0002, 0, 16'h0001, 1, 1);       // restarts, clips again
		write_reg(CFG_GRAV, 16'hFFFF);
		send_pair(5, 5, 32'shFFFF_FFF0, 32'sh0000_0100, 16'hFFFF, 1, 1);
		write_reg(CFG_GRAV, 16'h0000);
		send_pair(5, 5, 32'sh0010_0000, 32'sh0000_0100, 16'hFFFF, 1, 1);
		write_reg(CFG_SOFTENING, 32'hFFFF_FFFF);
		write_reg(CFG_GRAV, 16'hFFFF);
		send_pair(0, 0, 32'sh0001_0000, 0, 16'hFFFF, 1, 1);
		write_reg(2'd3, 32'h1234_5678);                            // unmapped index
		send_pair(0, 0, 32'sh0001_0000, 0, 16'hFFFF, 1, 1);
	endtask

	task automatic test_random_runs(input int pairs);
		int left, len, i;
		left = pairs;
		while (left > 0) begin
			len = $urandom_range(1, 8);
			for (i = 0; i < len && left > 0; i++, left--) begin
				logic f, l;
				f = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
				l = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
				send_pair(rand_pos(), rand_pos(), rand_pos(), rand_pos(), 16'($urandom), f, l);
			end
		end
	endtask

	task automatic test_settings();
		write_reg(CFG_SOFTENING, SOFTENING_RST);
		write_reg(CFG_GRAV, GRAV_RST);
		test_random_runs(400);
		write_reg(CFG_SOFTENING, $urandom_range(0, 32'h0010_0000));
		write_reg(CFG_GRAV, $urandom);
		test_random_runs(300);
		write_reg(CFG_SOFTENING, $urandom);
		write_reg(CFG_GRAV, 16'hFFFF);
		test_random_runs(150);
		stall_enable = 1'b0;
		write_reg(CFG_SOFTENING, 32'd1);
		write_reg(CFG_GRAV, 16'h0001);
		test_random_runs(100);
		stall_enable = 1'b1;
		write_reg(CFG_SOFTENING, 32'hFFFF_FFFF);
		write_reg(CFG_GRAV, 16'h0000);
		test_random_runs(80);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		in_valid <= 1'b0;
		wait (expected_accels.size() == 0);
		repeat (150) @(posedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
